>>> design/button_packet_decoder_core_assert.svh
// assertion macros shared by the button packet decoder modules
`ifndef BUTTON_PACKET_DECODER_CORE_ASSERT_SVH
`define BUTTON_PACKET_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define BPD_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define BPD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> design/bpd_pkg.sv
// shared types and constants of the button packet decoder
package bpd_pkg;

   // packet framing and button characters
   localparam logic [7:0] CH_START = 8'h21;
   localparam logic [7:0] CH_BLOCK = 8'h42;
   localparam logic [7:0] CH_FWD   = 8'h35;
   localparam logic [7:0] CH_BACK  = 8'h36;
   localparam logic [7:0] CH_LEFT  = 8'h37;
   localparam logic [7:0] CH_RIGHT = 8'h38;
   localparam logic [7:0] CH_PRESS = 8'h31;

   // configuration register map
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVE_OFFSET = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_OFFSET  = 1'd1;
   localparam logic [CSR_DATA_WIDTH-1:0]  DRIVE_OFFSET_RESET = 7'd40;
   localparam logic [CSR_DATA_WIDTH-1:0]  TURN_OFFSET_RESET  = 7'd30;

   // held flag bit positions
   localparam int unsigned HELD_FWD   = 0;
   localparam int unsigned HELD_BACK  = 1;
   localparam int unsigned HELD_LEFT  = 2;
   localparam int unsigned HELD_RIGHT = 3;

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_BLOCK  = 3'd1,
      PH_BUTTON = 3'd2,
      PH_PRESS  = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   // outcome of one byte as seen by the button logic
   typedef struct packed {
      logic       accepted;
      logic       bad;
      logic [7:0] button;
      logic [7:0] press;
   } pkt_type;

endpackage

>>> design/bpd_parser.sv
// packet framing state machine and checksum check
module bpd_parser
   import bpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output pkt_type    pkt
);

   phase_type  phase_ff, phase_in;
   logic [7:0] button_ff, button_in;
   logic [7:0] press_ff, press_in;
   logic [7:0] expect_sum;

   // inverse of the 8-bit sum of the first four bytes
   assign expect_sum = ~(CH_START + CH_BLOCK + button_ff + press_ff);

   // next phase and captured bytes
   always_comb begin
      phase_in  = phase_ff;
      button_in = button_ff;
      press_in  = press_ff;
      if (step) begin
         unique case (phase_ff)
            PH_BLOCK: begin
               phase_in = (rx_byte == CH_BLOCK) ? PH_BUTTON : PH_IDLE;
            end
            PH_BUTTON: begin
               button_in = rx_byte;
               phase_in  = PH_PRESS;
            end
            PH_PRESS: begin
               press_in = rx_byte;
               phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = (rx_byte == CH_START) ? PH_BLOCK : PH_IDLE;
            end
         endcase
      end
   end

   // outcome of the checksum byte
   always_comb begin
      pkt.accepted = 1'b0;
      pkt.bad      = 1'b0;
      pkt.button   = button_ff;
      pkt.press    = press_ff;
      if (step && (phase_ff == PH_CHECK)) begin
         pkt.accepted = (rx_byte == expect_sum);
         pkt.bad      = (rx_byte != expect_sum);
      end
   end

   // phase register and packet bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         button_ff <= 8'd0;
         press_ff  <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         button_ff <= button_in;
         press_ff  <= press_in;
      end
   end

`include "button_packet_decoder_core_assert.svh"

   `BPD_ASSERT_NOW(a_one_outcome, clock, reset, 1'b1, !(pkt.accepted && pkt.bad), "both outcomes at once")
   `BPD_ASSERT_NEXT(a_check_ends, clock, reset, step && (phase_ff == PH_CHECK), phase_ff == PH_IDLE, "parser did not return to idle after checksum")
   `BPD_ASSERT_NEXT(a_block_ok, clock, reset, step && (phase_ff == PH_BLOCK) && (rx_byte == CH_BLOCK), phase_ff == PH_BUTTON, "second byte not followed by button phase")
   `BPD_ASSERT_NEXT(a_hold_idle, clock, reset, !step, $stable(phase_ff) && $stable(button_ff) && $stable(press_ff), "parser moved without a beat")

endmodule

>>> design/bpd_button.sv
// held flags and steering offsets updated by good packets
module bpd_button
   import bpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  pkt_type                   pkt,
   input  logic [CSR_DATA_WIDTH-1:0] drive_offset,
   input  logic [CSR_DATA_WIDTH-1:0] turn_offset,
   output logic [3:0]                held,
   output logic [7:0]                left_offset,
   output logic [7:0]                right_offset
);

   logic [3:0] held_ff, held_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] right_ff, right_in;
   logic [7:0] drive_pos, drive_neg, turn_pos, turn_neg;
   logic [7:0] new_left, new_right;
   logic [3:0] sel;
   logic       known;

   // positive and negated offset magnitudes
   assign drive_pos = {1'b0, drive_offset};
   assign turn_pos  = {1'b0, turn_offset};
   assign drive_neg = 8'd0 - drive_pos;
   assign turn_neg  = 8'd0 - turn_pos;

   // decode the button number
   always_comb begin
      sel       = 4'd0;
      known     = 1'b1;
      new_left  = drive_pos;
      new_right = drive_pos;
      unique case (pkt.button)
         CH_FWD: begin
            sel[HELD_FWD] = 1'b1;
         end
         CH_BACK: begin
            sel[HELD_BACK] = 1'b1;
            new_left       = drive_neg;
            new_right      = drive_neg;
         end
         CH_LEFT: begin
            sel[HELD_LEFT] = 1'b1;
            new_left       = turn_pos;
            new_right      = turn_neg;
         end
         CH_RIGHT: begin
            sel[HELD_RIGHT] = 1'b1;
            new_left        = turn_neg;
            new_right       = turn_pos;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // press sets the flag and loads offsets, release clears the flag
   always_comb begin
      held_in  = held_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (pkt.accepted && known) begin
         if (pkt.press == CH_PRESS) begin
            held_in  = held_ff | sel;
            left_in  = new_left;
            right_in = new_right;
         end else begin
            held_in = held_ff & ~sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 4'd0;
         left_ff  <= 8'd0;
         right_ff <= 8'd0;
      end else begin
         held_ff  <= held_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign held         = held_ff;
   assign left_offset  = left_ff;
   assign right_offset = right_ff;

endmodule

>>> design/button_packet_decoder_core.sv
// Button packet decoder: takes one received serial byte per beat and returns one result
// per byte with the held flags, the steering offsets and the accept and bad-checksum
// pulses. Throughput is one byte per clock while rsp_ready does not hold the pipe; a
// byte waits in the input register and its result is loaded into the output register
// when the pipe advances, after which rsp_valid rises and the result beat can be taken.
// The parser state and the button state advance together with the output
// register, so a stalled rsp_ready holds the pipe, and the input register can still take
// one more byte while a finished result waits. csr_ writes load the drive and turn
// offsets (index 0 and 1) and are meant for idle periods only.
module button_packet_decoder_core
   import bpd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_forward_held,
   output logic                       rsp_backward_held,
   output logic                       rsp_left_held,
   output logic                       rsp_right_held,
   output logic signed [7:0]          rsp_left_offset,
   output logic signed [7:0]          rsp_right_offset,
   output logic                       rsp_packet_accepted,
   output logic                       rsp_checksum_bad,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff, in_byte_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accepted_ff, accepted_in;
   logic                      bad_ff, bad_in;
   logic [CSR_DATA_WIDTH-1:0] drive_ff, drive_in;
   logic [CSR_DATA_WIDTH-1:0] turn_ff, turn_in;
   logic                      advance;
   pkt_type                   pkt;
   logic [3:0]                held;
   logic [7:0]                left_offset;
   logic [7:0]                right_offset;

   // pipe moves when the output register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // output register for the pulses and valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      accepted_in  = accepted_ff;
      bad_in       = bad_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         accepted_in  = pkt.accepted;
         bad_in       = pkt.bad;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      drive_in = drive_ff;
      turn_in  = turn_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DRIVE_OFFSET: drive_in = csr_write_data;
            CSR_TURN_OFFSET:  turn_in  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drive_ff     <= DRIVE_OFFSET_RESET;
         turn_ff      <= TURN_OFFSET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         drive_ff     <= drive_in;
         turn_ff      <= turn_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      accepted_ff <= accepted_in;
      bad_ff      <= bad_in;
   end

   // framing and checksum
   bpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .pkt     (pkt)
   );

   // button state, which doubles as the result register for flags and offsets
   bpd_button u_button (
      .clock        (clock),
      .reset        (reset),
      .pkt          (pkt),
      .drive_offset (drive_ff),
      .turn_offset  (turn_ff),
      .held         (held),
      .left_offset  (left_offset),
      .right_offset (right_offset)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_forward_held    = held[HELD_FWD];
   assign rsp_backward_held   = held[HELD_BACK];
   assign rsp_left_held       = held[HELD_LEFT];
   assign rsp_right_held      = held[HELD_RIGHT];
   assign rsp_left_offset     = left_offset;
   assign rsp_right_offset    = right_offset;
   assign rsp_packet_accepted = accepted_ff;
   assign rsp_checksum_bad    = bad_ff;

`include "button_packet_decoder_core_assert.svh"

   `BPD_ASSERT_NOW(a_no_overrun, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_ready,
      !req_ready, "input taken while pipe is stalled")
   `BPD_ASSERT_NEXT(a_hold_byte, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "waiting beat lost from input register")
   `BPD_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_valid,
      "advanced beat produced no result")
   `BPD_ASSERT_NOW(a_pulses_exclusive, clock, reset, rsp_valid,
      !(rsp_packet_accepted && rsp_checksum_bad), "result flags accept and bad together")

endmodule

>>> tb/button_packet_decoder_core_checker.sv
// checker for the button packet decoder: mirrors the parser, predicts and compares each result
module button_packet_decoder_core_checker
   import bpd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_forward_held,
   input  logic                       rsp_backward_held,
   input  logic                       rsp_left_held,
   input  logic                       rsp_right_held,
   input  logic signed [7:0]          rsp_left_offset,
   input  logic signed [7:0]          rsp_right_offset,
   input  logic                       rsp_packet_accepted,
   input  logic                       rsp_checksum_bad,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                fail_count,
   output int unsigned                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // one result beat as the decoder should present it
   typedef struct packed {
      logic [3:0] flags;
      logic [7:0] left_offset;
      logic [7:0] right_offset;
      logic       accepted;
      logic       bad;
   } decoder_out_type;

   // mirror of the parser, the button state and the offset registers
   phase_type                 phase;
   logic [7:0]                button;
   logic [7:0]                press;
   logic [3:0]                held;
   logic [7:0]                left_off;
   logic [7:0]                right_off;
   logic [CSR_DATA_WIDTH-1:0] drive_mag;
   logic [CSR_DATA_WIDTH-1:0] turn_mag;

   decoder_out_type expected_outputs[$];
   int unsigned     mismatches = 0;

   assign fail_count = mismatches;

   // advance the mirrored parser by one byte and return the result it should give
   function automatic decoder_out_type decode_byte(input logic [7:0] rx);
      decoder_out_type res;
      logic [7:0]      sum;
      logic [7:0]      drive8;
      logic [7:0]      turn8;
      logic [7:0]      l;
      logic [7:0]      r;
      int              idx;
      res    = '0;
      drive8 = {1'b0, drive_mag};
      turn8  = {1'b0, turn_mag};
      l      = 8'h00;
      r      = 8'h00;
      idx    = -1;
      case (phase)
         PH_BLOCK: begin
            // a wrong second byte is swallowed, not rechecked as a start
            phase = (rx == CH_BLOCK) ? PH_BUTTON : PH_IDLE;
         end
         PH_BUTTON: begin
            button = rx;
            phase  = PH_PRESS;
         end
         PH_PRESS: begin
            press = rx;
            phase = PH_CHECK;
         end
         PH_CHECK: begin
            sum = CH_START + CH_BLOCK + button + press;
            if (rx == ~sum) begin
               res.accepted = 1'b1;
               case (button)
                  CH_FWD: begin
                     idx = HELD_FWD;
                     l   = drive8;
                     r   = drive8;
                  end
                  CH_BACK: begin
                     idx = HELD_BACK;
                     l   = 8'd0 - drive8;
                     r   = 8'd0 - drive8;
                  end
                  CH_LEFT: begin
                     idx = HELD_LEFT;
                     l   = turn8;
                     r   = 8'd0 - turn8;
                  end
                  CH_RIGHT: begin
                     idx = HELD_RIGHT;
                     l   = 8'd0 - turn8;
                     r   = turn8;
                  end
                  default: idx = -1;
               endcase
               // unknown buttons are accepted but touch nothing
               if (idx >= 0) begin
                  if (press == CH_PRESS) begin
                     held[idx] = 1'b1;
                     left_off  = l;
                     right_off = r;
                  end else begin
                     held[idx] = 1'b0;
                  end
               end
            end else begin
               res.bad = 1'b1;
            end
            phase = PH_IDLE;
         end
         default: begin
            phase = (rx == CH_START) ? PH_BLOCK : PH_IDLE;
         end
      endcase
      res.flags        = held;
      res.left_offset  = left_off;
      res.right_offset = right_off;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 'h%02h actual 'h%02h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      decoder_out_type got;
      decoder_out_type want;
      if (reset) begin
         phase     = PH_IDLE;
         button    = 8'h00;
         press     = 8'h00;
         held      = 4'h0;
         left_off  = 8'h00;
         right_off = 8'h00;
         drive_mag = DRIVE_OFFSET_RESET;
         turn_mag  = TURN_OFFSET_RESET;
         expected_outputs.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            if (csr_index == CSR_DRIVE_OFFSET)
               drive_mag = csr_write_data;
            else if (csr_index == CSR_TURN_OFFSET)
               turn_mag = csr_write_data;
         end

         // result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = {rsp_right_held, rsp_left_held, rsp_backward_held, rsp_forward_held,
                   rsp_left_offset, rsp_right_offset, rsp_packet_accepted, rsp_checksum_bad};
            if (expected_outputs.size() == 0) begin
               $display("%0t: result beat with no byte outstanding", $time);
               mismatches++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("forward_held", 8'(want.flags[HELD_FWD]), 8'(got.flags[HELD_FWD]));
               check_field("backward_held", 8'(want.flags[HELD_BACK]),
                           8'(got.flags[HELD_BACK]));
               check_field("left_held", 8'(want.flags[HELD_LEFT]), 8'(got.flags[HELD_LEFT]));
               check_field("right_held", 8'(want.flags[HELD_RIGHT]),
                           8'(got.flags[HELD_RIGHT]));
               check_field("left_offset", want.left_offset, got.left_offset);
               check_field("right_offset", want.right_offset, got.right_offset);
               check_field("packet_accepted", 8'(want.accepted), 8'(got.accepted));
               check_field("checksum_bad", 8'(want.bad), 8'(got.bad));
            end
         end

         // byte beat into the prediction store
         if (req_valid && req_ready)
            expected_outputs.push_back(decode_byte(req_rx_byte));
      end
      outstanding <= expected_outputs.size();
   end

endmodule

>>> tb/button_packet_decoder_core_tb.sv
// testbench top for the button packet decoder: clock, reset, byte traffic and verdict
module button_packet_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned ITEMS_PER_PHASE  = 225;
   localparam int unsigned DIRECTED_BYTES   = 25;
   localparam int unsigned LONG_HOLD_CYCLES = 150;
   localparam int unsigned DRAIN_CYCLES     = 6;
   localparam int unsigned PHASES           = 6;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte      = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic                       rsp_forward_held;
   logic                       rsp_backward_held;
   logic                       rsp_left_held;
   logic                       rsp_right_held;
   logic signed [7:0]          rsp_left_offset;
   logic signed [7:0]          rsp_right_offset;
   logic                       rsp_packet_accepted;
   logic                       rsp_checksum_bad;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = CSR_DRIVE_OFFSET;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned cycle_count   = 0;
   bit          req_gapless   = 1'b0;
   bit          rsp_gapless   = 1'b0;
   bit          rsp_long_hold = 1'b0;

   always #10 clock = ~clock;

   button_packet_decoder_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_forward_held    (rsp_forward_held),
      .rsp_backward_held   (rsp_backward_held),
      .rsp_left_held       (rsp_left_held),
      .rsp_right_held      (rsp_right_held),
      .rsp_left_offset     (rsp_left_offset),
      .rsp_right_offset    (rsp_right_offset),
      .rsp_packet_accepted (rsp_packet_accepted),
      .rsp_checksum_bad    (rsp_checksum_bad),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   button_packet_decoder_core_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_forward_held    (rsp_forward_held),
      .rsp_backward_held   (rsp_backward_held),
      .rsp_left_held       (rsp_left_held),
      .rsp_right_held      (rsp_right_held),
      .rsp_left_offset     (rsp_left_offset),
      .rsp_right_offset    (rsp_right_offset),
      .rsp_packet_accepted (rsp_packet_accepted),
      .rsp_checksum_bad    (rsp_checksum_bad),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // offer one byte beat and hold it until the decoder takes it
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      gap = req_gapless ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // five-byte packet; a nonzero corrupt pattern spoils the checksum
   task automatic send_packet(input logic [7:0] button, input logic [7:0] press,
                              input logic [7:0] corrupt);
      logic [7:0] sum;
      sum = CH_START + CH_BLOCK + button + press;
      send_byte(CH_START);
      send_byte(CH_BLOCK);
      send_byte(button);
      send_byte(press);
      send_byte(~sum ^ corrupt);
   endtask

   // stop offering and wait until every result is back, plus a short margin
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_offsets(input logic [6:0] drive, input logic [6:0] turn);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DRIVE_OFFSET;
      csr_write_data   <= drive;
      @(posedge clock);
      csr_index        <= CSR_TURN_OFFSET;
      csr_write_data   <= turn;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly good packets with random content, some idle noise, aborted headers
   // and packets cut short so that later bytes land in the wrong slots
   task automatic send_random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned noise;
      logic [7:0]  button;
      logic [7:0]  press;
      logic [7:0]  corrupt;
      sent = 0;
      while (sent < count) begin
         pick   = $urandom_range(0, 99);
         button = ($urandom_range(0, 9) < 8) ? CH_FWD + 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(0, 255));
         press  = ($urandom_range(0, 9) < 6) ? CH_PRESS : 8'($urandom_range(0, 255));
         if (pick < 70) begin
            corrupt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            send_packet(button, press, corrupt);
            sent += 5;
         end else if (pick < 80) begin
            noise = $urandom_range(1, 3);
            repeat (noise) send_byte(8'($urandom_range(0, 255)));
            sent += noise;
         end else if (pick < 90) begin
            send_byte(CH_START);
            send_byte(8'($urandom_range(0, 255)));
            sent += 2;
         end else begin
            send_byte(CH_START);
            send_byte(CH_BLOCK);
            send_byte(button);
            sent += 3;
         end
      end
   endtask

   // result side: random stall per beat, gapless stretches, one long hold-off on request
   initial begin : receiver
      int unsigned stall;
      @(negedge reset);
      forever begin
         if (rsp_long_hold) begin
            stall         = LONG_HOLD_CYCLES;
            rsp_long_hold = 1'b0;
         end else begin
            stall = rsp_gapless ? 0 : $urandom_range(0, 19);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("button_packet_decoder_core_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: idle extremes, good press, swallowed second byte, bad checksum,
      // unknown button, release
      send_byte(8'h00);
      send_byte(8'hFF);
      send_packet(CH_FWD, CH_PRESS, 8'h00);
      send_byte(CH_START);
      send_byte(CH_START);
      send_byte(CH_BLOCK);
      send_packet(CH_LEFT, CH_PRESS, 8'h01);
      send_packet(8'hFF, 8'h00, 8'h00);
      send_packet(CH_FWD, 8'h30, 8'h00);

      // first phase runs on the reset offsets
      send_random_traffic(ITEMS_PER_PHASE - DIRECTED_BYTES);

      for (int p = 1; p < PHASES; p++) begin
         wait_drained();
         case (p)
            1:       write_offsets(7'd0, 7'd127);
            2:       write_offsets(7'd127, 7'd0);
            3:       write_offsets(7'd100, 7'd100);
            default: write_offsets(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
         endcase
         req_gapless = ($urandom_range(0, 3) == 0);
         rsp_gapless = ($urandom_range(0, 3) == 0);
         // long receiver hold-off while bytes keep coming back to back
         if (p == 2) begin
            rsp_long_hold = 1'b1;
            req_gapless   = 1'b1;
            send_random_traffic(60);
            req_gapless   = 1'b0;
         end
         send_random_traffic(ITEMS_PER_PHASE);
      end

      wait_drained();
      if (fail_count == 0)
         $display("button_packet_decoder_core_tb OK");
      else
         $display("button_packet_decoder_core_tb NOT OK");
      $finish;
   end

endmodule
